FILE: src/spq_pkg.sv
// Package for the sorted-array priority queue: sizes, entry type, codes.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;
  localparam int WEIGHT_W = 16;
  localparam int NODE_W   = 8;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL_DROP  = 2'd1,
    STATUS_EMPTY_READ = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]          from_node;
    logic [NODE_W-1:0]          to_node;
  } entry_t;

  // broadcast to every cell for one operation
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/spq_cell.sv
// One slot of the sorted chain: compares, then keeps, shifts up or shifts down.
`default_nettype none
module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               left_hit,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire spq_pkg::entry_t    right_entry,
  output logic                    hit,
  output spq_pkg::entry_t         entry
);

  spq_pkg::entry_t entry_next;

  // empty slots count as +infinity so the hit pattern stays monotone
  assign hit = !occupied || ($signed(ctrl.new_entry.weight) <= $signed(entry.weight));

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (left_hit) begin
        entry_next = left_entry;
      end else if (hit) begin
        entry_next = ctrl.new_entry;
      end
    end else if (ctrl.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

FILE: src/sorted_array_priority_queue.sv
// Top level: sorted priority queue of weighted edges built as a chain of slots.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tuser: func; s_tdata: key_weight, from_node, to_node
//  m_*      out  m_tvalid/m_tready   m_tuser: status; m_tdata: out_weight .. now_full
//
// One transaction per cycle while s_tready is high: every slot compares
// against the new key in the same cycle and the whole chain moves at the
// accepting edge; the result is registered and shows on m_* the following cycle.
// s_tready is high whenever the output register is empty or being drained.
// Reset (rst, synchronous) clears the count and output valid; slot contents
// are left as they are, only slots below the count are ever read.
`default_nettype none
module sorted_array_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] key_weight, [23:16] from_node, [31:24] to_node
  input  wire logic [0:0]  s_tuser,   // [0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [15:0] out_weight, [23:16] out_from, [31:24] out_to,
                                      // [36:32] occupancy, [37] now_empty, [38] now_full,
                                      // [39] zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int N = spq_pkg::CAPACITY;

  logic                          accept;
  logic [spq_pkg::CNT_W-1:0]     count;
  logic [spq_pkg::CNT_W-1:0]     count_next;
  logic                          is_full;
  logic                          is_empty;
  spq_pkg::func_t                func;
  spq_pkg::cell_ctrl_t           ctrl;
  spq_pkg::status_t              status_next;
  logic [N-1:0]                  occ;
  logic [N-1:0]                  hit;
  spq_pkg::entry_t               slot [N];
  logic [39:0]                   data_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign func     = spq_pkg::func_t'(s_tuser[0]);
  assign is_full  = (count == spq_pkg::CNT_W'(N));
  assign is_empty = (count == '0);

  // decide the operation and its status before the chain moves
  always_comb begin
    ctrl.ins                 = 1'b0;
    ctrl.rem                 = 1'b0;
    ctrl.new_entry.weight    = s_tdata[15:0];
    ctrl.new_entry.from_node = s_tdata[23:16];
    ctrl.new_entry.to_node   = s_tdata[31:24];
    count_next  = count;
    status_next = spq_pkg::STATUS_OK;
    case (func)
      spq_pkg::FUNC_INSERT: begin
        if (is_full) begin
          status_next = spq_pkg::STATUS_FULL_DROP;
        end else begin
          ctrl.ins   = accept;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::FUNC_REMOVE: begin
        if (is_empty) begin
          status_next = spq_pkg::STATUS_EMPTY_READ;
        end else begin
          ctrl.rem   = accept;
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = spq_pkg::STATUS_OK;
      end
    endcase
  end

  // the chain: slot 0 holds the lowest weight
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i] = (count > spq_pkg::CNT_W'(i));
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[i]),
      .left_hit    ((i == 0) ? 1'b0 : hit[(i == 0) ? 0 : i - 1]),
      .left_entry  (slot[(i == 0) ? 0 : i - 1]),
      .right_entry (slot[(i == N - 1) ? N - 1 : i + 1]),
      .hit         (hit[i]),
      .entry       (slot[i])
    );
  end

  // result word; the removed edge is read from the head slot
  always_comb begin
    data_next = '0;
    if (ctrl.rem) begin
      data_next[15:0]  = slot[0].weight;
      data_next[23:16] = slot[0].from_node;
      data_next[31:24] = slot[0].to_node;
    end
    data_next[36:32] = spq_pkg::OCC_W'(count_next);
    data_next[37]    = (count_next == '0);
    data_next[38]    = (count_next == spq_pkg::CNT_W'(N));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= data_next;
      m_tuser <= status_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/spq_checker.sv
// Port-level checks for the priority queue, bound to the top level.
`default_nettype none
module spq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // empty flag agrees with occupancy and excludes full
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[37] |-> m_tdata[36:32] == 5'd0 && !m_tdata[38])
    else $error("empty flag inconsistent");

  // a rejected insert leaves the queue full, no edge reported
  a_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == spq_pkg::STATUS_FULL_DROP |-> m_tdata[38] && m_tdata[31:0] == '0)
    else $error("full reject inconsistent");

  // a remove on empty leaves the queue empty, no edge reported
  a_underrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == spq_pkg::STATUS_EMPTY_READ |-> m_tdata[37] && m_tdata[31:0] == '0)
    else $error("empty remove inconsistent");

endmodule

bind sorted_array_priority_queue spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
